FILE: rtl/gkrm_pkg.sv
// Shared codes, types and a lookup function for the gamepad key repeat mapper.
package gkrm_pkg;

  // Default sizes
  localparam int PADS_DEF    = 4;
  localparam int BUTTONS_DEF = 32;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int PAD_IN_W = 2;
  localparam int INDEX_W  = 8;
  localparam int VALUE_W  = 16;
  localparam int KEY_W    = 4;
  localparam int ACT_W    = 3;
  localparam int DZ_W     = 15;
  localparam int TICK_W   = 16;
  localparam int EN_W     = 4;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_BUTTON = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AXIS   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ENABLE = 2'd3;

  // Configuration reset values
  localparam logic [DZ_W-1:0]   DEADZONE_RST   = 15'd8191;
  localparam logic [TICK_W-1:0] DELAY_RST      = 16'd400;
  localparam logic [TICK_W-1:0] INTERVAL_RST   = 16'd100;
  localparam logic [EN_W-1:0]   PAD_ENABLE_RST = 4'hF;
  localparam logic [TICK_W-1:0] ELAPSED_MAX    = 16'hFFFF;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_NONE    = 4'd0;
  localparam logic [KEY_W-1:0] KEY_ENTER   = 4'd1;
  localparam logic [KEY_W-1:0] KEY_ESC     = 4'd2;
  localparam logic [KEY_W-1:0] KEY_OPTIONS = 4'd3;
  localparam logic [KEY_W-1:0] KEY_SEARCH  = 4'd4;
  localparam logic [KEY_W-1:0] KEY_OPEN    = 4'd5;
  localparam logic [KEY_W-1:0] KEY_LT      = 4'd6;
  localparam logic [KEY_W-1:0] KEY_RT      = 4'd7;
  localparam logic [KEY_W-1:0] KEY_UP      = 4'd8;
  localparam logic [KEY_W-1:0] KEY_DN      = 4'd9;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PLAY    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_BACK    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_OPTIONS = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SEARCH  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PREV    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_NEXT    = 3'd6;
  localparam logic [ACT_W-1:0] ACT_OPEN    = 3'd7;

  // Button numbers
  localparam logic [INDEX_W-1:0] BTN_A       = 8'd0;
  localparam logic [INDEX_W-1:0] BTN_B       = 8'd1;
  localparam logic [INDEX_W-1:0] BTN_X       = 8'd2;
  localparam logic [INDEX_W-1:0] BTN_Y       = 8'd3;
  localparam logic [INDEX_W-1:0] BTN_LB      = 8'd4;
  localparam logic [INDEX_W-1:0] BTN_RB      = 8'd5;
  localparam logic [INDEX_W-1:0] BTN_BACK    = 8'd8;
  localparam logic [INDEX_W-1:0] BTN_START   = 8'd9;
  localparam logic [INDEX_W-1:0] BTN_MENU    = 8'd10;

  // Axis numbers
  localparam logic [INDEX_W-1:0] AXIS_X      = 8'd0;
  localparam logic [INDEX_W-1:0] AXIS_Y      = 8'd1;
  localparam logic [INDEX_W-1:0] AXIS_HAT_X  = 8'd5;
  localparam logic [INDEX_W-1:0] AXIS_HAT_Y  = 8'd6;

  // Button map entry
  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] key;
    logic [ACT_W-1:0] act;
  } btn_map_t;

  // Controller to datapath commands
  typedef struct packed {
    logic cap_in;
    logic do_event;
    logic do_tick;
    logic emit_event;
    logic emit_tick;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_tick;
    logic in_event;
    logic ev_fire;
    logic tick_done;
    logic mask_empty;
    logic mask_last;
    logic out_free;
  } sts_t;

  // Map a button press edge to key and action
  function automatic btn_map_t btn_map(input logic [INDEX_W-1:0] idx);
    btn_map_t m;
    m = '{hit: 1'b1, key: KEY_NONE, act: ACT_NONE};
    case (idx)
      BTN_A:     begin m.key = KEY_ENTER;   m.act = ACT_PLAY;    end
      BTN_B:     begin m.key = KEY_ESC;     m.act = ACT_BACK;    end
      BTN_X:     begin m.key = KEY_OPTIONS; m.act = ACT_OPTIONS; end
      BTN_Y:     begin m.key = KEY_SEARCH;  m.act = ACT_SEARCH;  end
      BTN_LB:    begin m.key = KEY_NONE;    m.act = ACT_PREV;    end
      BTN_RB:    begin m.key = KEY_NONE;    m.act = ACT_NEXT;    end
      BTN_BACK:  begin m.key = KEY_NONE;    m.act = ACT_BACK;    end
      BTN_START: begin m.key = KEY_OPEN;    m.act = ACT_OPEN;    end
      BTN_MENU:  begin m.key = KEY_OPEN;    m.act = ACT_OPEN;    end
      default:   m.hit = 1'b0;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/gkrm_datapath.sv
// Datapath: config registers, per-pad state, event and tick evaluation, output register.
module gkrm_datapath #(
  parameter int PADS    = gkrm_pkg::PADS_DEF,
  parameter int BUTTONS = gkrm_pkg::BUTTONS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gkrm_pkg::cmd_t                       cmd_i,
  output gkrm_pkg::sts_t                       sts_o,
  input  logic                                 cfg_we_i,
  input  logic [gkrm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gkrm_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [gkrm_pkg::MODE_W-1:0]          mode_i,
  input  logic [gkrm_pkg::PAD_IN_W-1:0]        pad_i,
  input  logic [gkrm_pkg::INDEX_W-1:0]         index_i,
  input  logic signed [gkrm_pkg::VALUE_W-1:0]  value_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [gkrm_pkg::PAD_IN_W-1:0]        out_pad_o,
  output logic [gkrm_pkg::KEY_W-1:0]           key_code_o,
  output logic [gkrm_pkg::ACT_W-1:0]           action_o,
  output logic                                 auto_repeat_o,
  output logic                                 last_o
);
  import gkrm_pkg::*;

  localparam int PAD_W = (PADS > 1) ? $clog2(PADS) : 1;
  localparam int BTN_W = $clog2(BUTTONS);

  // Configuration registers
  logic [DZ_W-1:0]   deadzone_q;
  logic [TICK_W-1:0] delay_q;
  logic [TICK_W-1:0] interval_q;
  logic [EN_W-1:0]   enable_q;

  // Captured input word
  logic [PAD_IN_W-1:0]       in_pad_q;
  logic [INDEX_W-1:0]        in_idx_q;
  logic signed [VALUE_W-1:0] in_val_q;
  logic                      in_axis_q;

  // Per-pad state
  logic [BUTTONS-1:0] bits_q    [PADS];
  logic [KEY_W-1:0]   held_q    [PADS];
  logic [TICK_W-1:0]  elapsed_q [PADS];
  logic               fired_q   [PADS];

  // Tick walk
  logic [PAD_W-1:0] cnt_q;
  logic [PADS-1:0]  mask_q;

  // Output register
  logic                out_valid_q;
  logic [PAD_IN_W-1:0] out_pad_q;
  logic [KEY_W-1:0]    out_key_q;
  logic [ACT_W-1:0]    out_act_q;
  logic                out_rep_q;
  logic                out_last_q;

  // Event result, held from evaluation until it is emitted
  logic [KEY_W-1:0] ev_key_q;
  logic [ACT_W-1:0] ev_act_q;

  logic [PADS+EN_W-1:0] en_ext;
  logic [PADS-1:0]      en_vec;
  logic [PAD_W-1:0]     low_pad;
  logic [PADS-1:0]      low_onehot;
  logic [PADS-1:0]      mask_rest;
  logic [PAD_W-1:0]     addr;
  logic [PAD_W-1:0]     ev_pad;

  logic [BUTTONS-1:0] rd_bits;
  logic [KEY_W-1:0]   rd_held;
  logic [TICK_W-1:0]  rd_elapsed;
  logic               rd_fired;

  logic [BUTTONS-1:0] ev_bits;
  logic [KEY_W-1:0]   ev_held;
  logic [TICK_W-1:0]  ev_elapsed;
  logic               ev_fired;
  logic               ev_fire;
  logic [KEY_W-1:0]   ev_key;
  logic [ACT_W-1:0]   ev_act;
  logic               ev_live;

  logic [BTN_W-1:0]   bsel;
  logic               was;
  logic               pressed;
  btn_map_t           bmap;
  logic               is_dir;
  logic [KEY_W-1:0]   neg_key;
  logic [KEY_W-1:0]   pos_key;
  logic [KEY_W-1:0]   dir_key;
  logic signed [VALUE_W:0] vs;
  logic signed [VALUE_W:0] dzs;

  logic               t_live;
  logic [TICK_W-1:0]  t_inc;
  logic [TICK_W-1:0]  t_thr;
  logic               t_fire;
  logic [TICK_W-1:0]  t_elapsed;
  logic               t_fired;

  logic               wr_en;
  logic [BUTTONS-1:0] wr_bits;
  logic [KEY_W-1:0]   wr_held;
  logic [TICK_W-1:0]  wr_elapsed;
  logic               wr_fired;

  // Pad enable widened to the pad count
  assign en_ext = {{PADS{1'b0}}, enable_q};
  assign en_vec = en_ext[PADS-1:0];

  // Pick the lowest pad that fired on this tick
  always_comb begin
    low_pad = '0;
    for (int i = PADS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        low_pad = PAD_W'(i);
      end
    end
  end

  assign low_onehot = PADS'(1) << low_pad;
  assign mask_rest  = mask_q & ~low_onehot;

  // Select the pad whose state is read and written
  assign ev_pad = PAD_W'(in_pad_q);
  always_comb begin
    if (cmd_i.emit_tick) begin
      addr = low_pad;
    end else if (cmd_i.do_tick) begin
      addr = cnt_q;
    end else begin
      addr = ev_pad;
    end
  end

  assign rd_bits    = bits_q[addr];
  assign rd_held    = held_q[addr];
  assign rd_elapsed = elapsed_q[addr];
  assign rd_fired   = fired_q[addr];

  // Evaluate a button or axis event
  assign ev_live = (32'(in_pad_q) < PADS) && en_vec[ev_pad];
  assign bsel    = in_idx_q[BTN_W-1:0];
  assign was     = rd_bits[bsel];
  assign pressed = (in_val_q != '0);
  assign bmap    = btn_map(in_idx_q);
  assign vs      = (VALUE_W + 1)'(in_val_q);
  assign dzs     = signed'({2'b00, deadzone_q});

  always_comb begin
    is_dir  = 1'b1;
    neg_key = KEY_LT;
    pos_key = KEY_RT;
    case (in_idx_q) inside
      AXIS_X, AXIS_HAT_X: begin
        neg_key = KEY_LT;
        pos_key = KEY_RT;
      end
      AXIS_Y, AXIS_HAT_Y: begin
        neg_key = KEY_UP;
        pos_key = KEY_DN;
      end
      default: is_dir = 1'b0;
    endcase
  end

  always_comb begin
    if (vs < -dzs) begin
      dir_key = neg_key;
    end else if (vs > dzs) begin
      dir_key = pos_key;
    end else begin
      dir_key = KEY_NONE;
    end
  end

  always_comb begin
    ev_bits    = rd_bits;
    ev_held    = rd_held;
    ev_elapsed = rd_elapsed;
    ev_fired   = rd_fired;
    ev_fire    = 1'b0;
    ev_key     = KEY_NONE;
    ev_act     = ACT_NONE;
    if (ev_live && !in_axis_q) begin
      if (32'(in_idx_q) < BUTTONS) begin
        ev_bits[bsel] = pressed;
        if (!pressed) begin
          ev_held = KEY_NONE;
        end else if (!was && bmap.hit) begin
          ev_fire = 1'b1;
          ev_key  = bmap.key;
          ev_act  = bmap.act;
          if (bmap.key == KEY_ENTER) begin
            ev_held    = KEY_ENTER;
            ev_elapsed = '0;
            ev_fired   = 1'b0;
          end
        end
      end
    end else if (ev_live && in_axis_q && is_dir) begin
      if (dir_key != KEY_NONE && dir_key != rd_held) begin
        ev_fire    = 1'b1;
        ev_key     = dir_key;
        ev_held    = dir_key;
        ev_elapsed = '0;
        ev_fired   = 1'b0;
      end else if (dir_key == KEY_NONE && (rd_held == neg_key || rd_held == pos_key)) begin
        ev_held = KEY_NONE;
      end
    end
  end

  // Evaluate one pad of a tick
  assign t_live = en_vec[cnt_q];
  assign t_inc  = (rd_elapsed == ELAPSED_MAX) ? rd_elapsed : rd_elapsed + 1'b1;
  assign t_thr  = rd_fired ? interval_q : delay_q;
  assign t_fire = t_live && (rd_held != KEY_NONE) && (t_inc >= t_thr);
  assign t_elapsed = t_fire ? '0 : t_inc;
  assign t_fired   = t_fire ? 1'b1 : rd_fired;

  // Merge the state write
  always_comb begin
    wr_en      = 1'b0;
    wr_bits    = ev_bits;
    wr_held    = ev_held;
    wr_elapsed = ev_elapsed;
    wr_fired   = ev_fired;
    if (cmd_i.do_event) begin
      wr_en = ev_live;
    end else if (cmd_i.do_tick) begin
      wr_en      = t_live;
      wr_bits    = rd_bits;
      wr_held    = rd_held;
      wr_elapsed = t_elapsed;
      wr_fired   = t_fired;
    end
  end

  // Update per-pad state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PADS; i++) begin
        bits_q[i]    <= '0;
        held_q[i]    <= KEY_NONE;
        elapsed_q[i] <= '0;
        fired_q[i]   <= 1'b0;
      end
    end else if (wr_en) begin
      bits_q[addr]    <= wr_bits;
      held_q[addr]    <= wr_held;
      elapsed_q[addr] <= wr_elapsed;
      fired_q[addr]   <= wr_fired;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= DEADZONE_RST;
      delay_q    <= DELAY_RST;
      interval_q <= INTERVAL_RST;
      enable_q   <= PAD_ENABLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEADZONE:   deadzone_q <= cfg_data_i[DZ_W-1:0];
        REG_DELAY:      delay_q    <= cfg_data_i[TICK_W-1:0];
        REG_INTERVAL:   interval_q <= cfg_data_i[TICK_W-1:0];
        REG_PAD_ENABLE: enable_q   <= cfg_data_i[EN_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      in_pad_q  <= pad_i;
      in_idx_q  <= index_i;
      in_val_q  <= value_i;
      in_axis_q <= (mode_i == MODE_AXIS);
    end
  end

  // Walk pads and record which ones fire
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mask_q <= '0;
    end else if (cmd_i.cap_in) begin
      cnt_q  <= '0;
      mask_q <= '0;
    end else if (cmd_i.do_tick) begin
      cnt_q         <= cnt_q + 1'b1;
      mask_q[cnt_q] <= t_fire;
    end else if (cmd_i.emit_tick) begin
      mask_q <= mask_rest;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_event || cmd_i.emit_tick) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_event) begin
      out_pad_q  <= in_pad_q;
      out_key_q  <= ev_key_q;
      out_act_q  <= ev_act_q;
      out_rep_q  <= 1'b0;
      out_last_q <= 1'b1;
    end else if (cmd_i.emit_tick) begin
      out_pad_q  <= PAD_IN_W'(low_pad);
      out_key_q  <= rd_held;
      out_act_q  <= ACT_NONE;
      out_rep_q  <= 1'b1;
      out_last_q <= (mask_rest == '0);
    end
  end

  // Event result is captured together with the state write
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_event) begin
      ev_key_q <= ev_key;
      ev_act_q <= ev_act;
    end
  end

  // Report status
  assign sts_o.in_tick    = (mode_i == MODE_TICK);
  assign sts_o.in_event   = (mode_i == MODE_BUTTON) || (mode_i == MODE_AXIS);
  assign sts_o.ev_fire    = ev_fire;
  assign sts_o.tick_done  = (cnt_q == PAD_W'(PADS - 1));
  assign sts_o.mask_empty = (mask_q == '0);
  assign sts_o.mask_last  = (mask_rest == '0);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign out_pad_o     = out_pad_q;
  assign key_code_o    = out_key_q;
  assign action_o      = out_act_q;
  assign auto_repeat_o = out_rep_q;
  assign last_o        = out_last_q;

endmodule

FILE: rtl/gkrm_ctrl.sv
// Controller: sequences capture, event evaluation, tick walk and result emission.
module gkrm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gkrm_pkg::sts_t sts_i,
  output gkrm_pkg::cmd_t cmd_o
);
  import gkrm_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EVENT    = 3'd1;
  localparam logic [2:0] S_EVT_OUT  = 3'd2;
  localparam logic [2:0] S_TICK     = 3'd3;
  localparam logic [2:0] S_TICK_OUT = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          if (sts_i.in_tick) begin
            state_d = S_TICK;
          end else if (sts_i.in_event) begin
            state_d = S_EVENT;
          end
        end
      end
      S_EVENT: begin
        cmd_o.do_event = 1'b1;
        state_d = sts_i.ev_fire ? S_EVT_OUT : S_IDLE;
      end
      S_EVT_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_event = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TICK: begin
        cmd_o.do_tick = 1'b1;
        if (sts_i.tick_done) begin
          state_d = S_TICK_OUT;
        end
      end
      S_TICK_OUT: begin
        if (sts_i.mask_empty) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit_tick = 1'b1;
          if (sts_i.mask_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

FILE: rtl/gamepad_key_repeat_mapper.sv
// Top level of the gamepad key repeat mapper: controller plus datapath.
// Button or axis word: accepted, evaluated in the next cycle; a result waits in S_EVT_OUT
// until the output is free and is then registered; without a result it returns to idle.
// Tick word: accepted, then the pads are walked one per cycle; results are then emitted one
// per cycle while the output is not stalled, or the controller returns to idle when no pad fires.
// Reset clears pad state and the controller and loads the register defaults at once.
module gamepad_key_repeat_mapper #(
  parameter int PADS    = gkrm_pkg::PADS_DEF,
  parameter int BUTTONS = gkrm_pkg::BUTTONS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [gkrm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gkrm_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [gkrm_pkg::MODE_W-1:0]          mode_i,
  input  logic [gkrm_pkg::PAD_IN_W-1:0]        pad_i,
  input  logic [gkrm_pkg::INDEX_W-1:0]         index_i,
  input  logic signed [gkrm_pkg::VALUE_W-1:0]  value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [gkrm_pkg::PAD_IN_W-1:0]        out_pad_o,
  output logic [gkrm_pkg::KEY_W-1:0]           key_code_o,
  output logic [gkrm_pkg::ACT_W-1:0]           action_o,
  output logic                                 auto_repeat_o,
  output logic                                 last_o
);
  import gkrm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gkrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gkrm_datapath #(
    .PADS    (PADS),
    .BUTTONS (BUTTONS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (mode_i),
    .pad_i         (pad_i),
    .index_i       (index_i),
    .value_i       (value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_pad_o     (out_pad_o),
    .key_code_o    (key_code_o),
    .action_o      (action_o),
    .auto_repeat_o (auto_repeat_o),
    .last_o        (last_o)
  );

endmodule
